>>> rtl/core/bgca_pkg.sv
// bgca_pkg: shared constants, register indexes and types for the grid smoothing block.
// No dependencies; every other file of the block imports it.
package bgca_pkg;

	localparam int ROW_W      = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 4096;
	localparam int NUM_W      = 12;
	localparam int GW_W       = 7;
	localparam int GH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int OQ_DEPTH   = 4;
	localparam int OQ_PTR_W   = 2;
	localparam int OQ_CNT_W   = 3;

	// smoothing thresholds on the neighbor wall count
	localparam logic [3:0] WALL_ABOVE  = 4'd4;
	localparam logic [3:0] FLOOR_BELOW = 4'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [GW_W-1:0] GW_RESET = 7'd64;
	localparam logic [GH_W-1:0] GH_RESET = 13'd64;

	// one output result
	typedef struct packed {
		logic [ROW_W-1:0] cells;
		logic [NUM_W-1:0] num;
		logic             fin;
	} result_t;

	// rows handed to the smoothing lanes
	typedef struct packed {
		logic [ROW_W-1:0] up;
		logic [ROW_W-1:0] mid;
		logic [ROW_W-1:0] low;
		logic [GW_W-1:0]  width;
		logic             plain;
	} smooth_req_t;

	// writes into the output queue, up to two per cycle
	typedef struct packed {
		logic    en0;
		logic    en1;
		result_t res0;
		result_t res1;
	} oq_push_t;

	// queue status back to the top level
	typedef struct packed {
		logic [OQ_CNT_W-1:0] count;
	} oq_status_t;

	// mask of the columns in use; a width of 64 keeps all bits
	function automatic logic [ROW_W-1:0] width_mask(input logic [GW_W-1:0] w);
		width_mask = ~({ROW_W{1'b1}} << w);
	endfunction

endpackage

>>> rtl/core/bgca_if.sv
// bgca_if: valid/ready channel interfaces for grid rows in and smoothed rows out.
// Depends on bgca_pkg.
interface bgca_row_if;
	import bgca_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_cells;

	modport source (output valid, output row_cells, input ready);
	modport sink (input valid, input row_cells, output ready);
endinterface

interface bgca_res_if;
	import bgca_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] smoothed_cells;
	logic [NUM_W-1:0] row_number;
	logic             final_row;

	modport source (output valid, output smoothed_cells, output row_number,
		output final_row, input ready);
	modport sink (input valid, input smoothed_cells, input row_number,
		input final_row, output ready);
endinterface

>>> rtl/core/bgca_lane.sv
// bgca_lane: one interior cell, counts the 8 neighbors and applies the smoothing rule.
// Depends on bgca_pkg.
module bgca_lane (
	input  logic [2:0] up_win,
	input  logic [2:0] mid_win,
	input  logic [2:0] low_win,
	input  logic       en,
	output logic       wall_out
);
	import bgca_pkg::*;

	logic [3:0] walls;

	// neighbor count, center excluded
	assign walls = {3'b0, up_win[0]} + {3'b0, up_win[1]} + {3'b0, up_win[2]}
		+ {3'b0, mid_win[0]} + {3'b0, mid_win[2]}
		+ {3'b0, low_win[0]} + {3'b0, low_win[1]} + {3'b0, low_win[2]};

	always_comb begin
		wall_out = mid_win[1];
		if (en) begin
			if (walls > WALL_ABOVE) wall_out = 1'b1;
			else if (walls < FLOOR_BELOW) wall_out = 1'b0;
		end
	end

endmodule

>>> rtl/core/bgca_row_smoother.sv
// bgca_row_smoother: one lane per interior column and the merge into a full row.
// Depends on bgca_pkg and bgca_lane.
module bgca_row_smoother (
	input  bgca_pkg::smooth_req_t req,
	output logic [bgca_pkg::ROW_W-1:0] cells
);
	import bgca_pkg::*;

	logic [ROW_W-1:0] lane_out;

	// border columns keep the middle row
	assign lane_out[0]       = req.mid[0];
	assign lane_out[ROW_W-1] = req.mid[ROW_W-1];

	for (genvar x = 1; x < ROW_W - 1; x++) begin : g_lane
		logic lane_en;
		assign lane_en = (GW_W'(x + 1) < req.width);
		bgca_lane u_lane (
			.up_win   (req.up[x+1:x-1]),
			.mid_win  (req.mid[x+1:x-1]),
			.low_win  (req.low[x+1:x-1]),
			.en       (lane_en),
			.wall_out (lane_out[x])
		);
	end

	// top grid row passes through unchanged
	assign cells = req.plain ? req.mid : lane_out;

endmodule

>>> rtl/core/bgca_outq.sv
// bgca_outq: small result queue, up to two writes and one read per cycle.
// Depends on bgca_pkg and bgca_if.
module bgca_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bgca_pkg::oq_push_t    push,
	output bgca_pkg::oq_status_t  status,
	bgca_res_if.source            res_out
);
	import bgca_pkg::*;

	result_t             q_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;
	logic [OQ_CNT_W-1:0] n_push;
	logic [OQ_PTR_W-1:0] wr_ptr1;
	result_t             head;

	assign pop     = res_out.valid && res_out.ready;
	assign n_push  = {{(OQ_CNT_W-1){1'b0}}, push.en0} + {{(OQ_CNT_W-1){1'b0}}, push.en1};
	assign wr_ptr1 = wr_ptr_q + {{(OQ_PTR_W-1){1'b0}}, push.en0};

	// payload storage
	always_ff @(posedge clk) begin
		if (push.en0) q_mem[wr_ptr_q] <= push.res0;
		if (push.en1) q_mem[wr_ptr1] <= push.res1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[OQ_PTR_W-1:0];
			if (pop) rd_ptr_q <= rd_ptr_q + {{(OQ_PTR_W-1){1'b0}}, 1'b1};
			count_q <= count_q + n_push - {{(OQ_CNT_W-1){1'b0}}, pop};
		end
	end

	assign head                   = q_mem[rd_ptr_q];
	assign res_out.valid          = (count_q != '0);
	assign res_out.smoothed_cells = head.cells;
	assign res_out.row_number     = head.num;
	assign res_out.final_row      = head.fin;
	assign status.count           = count_q;

endmodule

>>> rtl/core/binary_grid_ca_smoothing.sv
// binary_grid_ca_smoothing: top level of the one-pass cave smoothing block.
// Depends on bgca_pkg, bgca_if, bgca_row_smoother and bgca_outq.
//
// Usage:
//   row_in carries one grid row per transfer, bit x = column x, 1 = wall.
//   res_out carries smoothed rows with their row number and a final_row flag.
//   Rows enter top to bottom; row k leaves once row k+1 has been taken, and
//   the last row of a pass (grid_height rows) also flushes itself, so that
//   transfer yields two results. The first row of a pass yields none.
//   Path: the capture stage registers the row transfer that completes a result,
//   the queue registers that result, and the queue head is offered on res_out.
//   Throughput: one row per cycle while res_out keeps up; at the end of a pass
//   row_in.ready drops while the four-entry output queue absorbs the double result.
//   Receiver stall: results wait in the queue; row_in.ready drops once the
//   queue and the capture stage together leave no room for two results.
//   Reset: pass state clears, grid_width and grid_height return to 64.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is for the user to write only while idle;
//   the block does not enforce this. Several passes are made by streaming the grid through again.
module binary_grid_ca_smoothing (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bgca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgca_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bgca_row_if.sink                        row_in,
	bgca_res_if.source                      res_out
);
	import bgca_pkg::*;

	logic [GW_W-1:0]  grid_width_q;
	logic [GH_W-1:0]  grid_height_q;
	logic [ROW_W-1:0] upper_q;
	logic [ROW_W-1:0] middle_q;
	logic [NUM_W-1:0] rows_seen_q;

	logic [GW_W-1:0]  w_eff;
	logic [GH_W-1:0]  h_eff;
	logic [ROW_W-1:0] mask;
	logic [ROW_W-1:0] row_m;
	logic             accept;
	logic             first_row;
	logic             last_row;

	logic             valid_s1;
	logic [1:0]       nres_s1;
	logic             plain_s1;
	logic [ROW_W-1:0] up_s1;
	logic [ROW_W-1:0] mid_s1;
	logic [ROW_W-1:0] low_s1;
	logic [GW_W-1:0]  w_s1;
	logic [NUM_W-1:0] num_s1;

	smooth_req_t      req;
	logic [ROW_W-1:0] smooth_cells;
	oq_push_t         push;
	oq_status_t       oq_stat;
	logic [OQ_CNT_W-1:0] reserved;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW_RESET;
			grid_height_q <= GH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[GW_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_wdata[GH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective width and height, saturated to their ranges
	always_comb begin
		w_eff = grid_width_q;
		if (w_eff < GW_W'(3)) w_eff = GW_W'(3);
		else if (w_eff > GW_W'(MAX_WIDTH)) w_eff = GW_W'(MAX_WIDTH);
		h_eff = grid_height_q;
		if (h_eff < GH_W'(3)) h_eff = GH_W'(3);
		else if (h_eff > GH_W'(MAX_HEIGHT)) h_eff = GH_W'(MAX_HEIGHT);
	end

	assign mask      = width_mask(w_eff);
	assign row_m     = row_in.row_cells & mask;
	assign first_row = (rows_seen_q == '0);
	assign last_row  = (({1'b0, rows_seen_q} + GH_W'(1)) >= h_eff);

	// room for the worst case of two results per row
	assign reserved     = valid_s1 ? {{(OQ_CNT_W-2){1'b0}}, nres_s1} : '0;
	assign row_in.ready = ((oq_stat.count + reserved) <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign accept       = row_in.valid && row_in.ready;

	// row window and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q     <= '0;
			middle_q    <= '0;
			rows_seen_q <= '0;
		end else if (accept) begin
			if (first_row) begin
				upper_q     <= '0;
				middle_q    <= row_m;
				rows_seen_q <= NUM_W'(1);
			end else if (last_row) begin
				upper_q     <= '0;
				middle_q    <= '0;
				rows_seen_q <= '0;
			end else begin
				upper_q     <= middle_q;
				middle_q    <= row_m;
				rows_seen_q <= rows_seen_q + NUM_W'(1);
			end
		end
	end

	// capture stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			nres_s1  <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) nres_s1 <= first_row ? 2'd0 : (last_row ? 2'd2 : 2'd1);
			else nres_s1 <= '0;
		end
	end

	// capture stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1    <= upper_q & mask;
			mid_s1   <= middle_q & mask;
			low_s1   <= row_m;
			w_s1     <= w_eff;
			plain_s1 <= (rows_seen_q == NUM_W'(1));
			num_s1   <= rows_seen_q;
		end
	end

	assign req.up    = up_s1;
	assign req.mid   = mid_s1;
	assign req.low   = low_s1;
	assign req.width = w_s1;
	assign req.plain = plain_s1;

	bgca_row_smoother u_smoother (
		.req   (req),
		.cells (smooth_cells)
	);

	// results into the queue: smoothed previous row, then the flushed last row
	assign push.en0       = valid_s1 && (nres_s1 != 2'd0);
	assign push.en1       = valid_s1 && (nres_s1 == 2'd2);
	assign push.res0.cells = smooth_cells;
	assign push.res0.num   = num_s1 - NUM_W'(1);
	assign push.res0.fin   = 1'b0;
	assign push.res1.cells = low_s1;
	assign push.res1.num   = num_s1;
	assign push.res1.fin   = 1'b1;

	bgca_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.status  (oq_stat),
		.res_out (res_out)
	);

	// queue never holds more than its depth
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_stat.count <= OQ_CNT_W'(OQ_DEPTH))
		else $error("output queue overflow");

	// the first row of a pass only primes the window
	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rows_seen_q == '0) |=> (rows_seen_q == NUM_W'(1) && nres_s1 == 2'd0))
		else $error("first row of a pass mishandled");

	// a double result leaves the queue non-empty
	a_flush_push: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && nres_s1 == 2'd2) |=> (oq_stat.count != '0))
		else $error("flushed last row lost");

endmodule

>>> sim/binary_grid_ca_smoothing_tb.sv
// binary_grid_ca_smoothing_tb: self-checking testbench for the one-pass grid smoothing block.
// Depends on bgca_pkg, bgca_if and the binary_grid_ca_smoothing RTL; streams rows in,
// predicts every smoothed row and compares each result transfer against the prediction.
module binary_grid_ca_smoothing_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bgca_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ROWS  = 400;
	localparam int TALL_ROWS    = 200;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bgca_row_if row_ch();
	bgca_res_if res_ch();

	binary_grid_ca_smoothing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.row_in    (row_ch.sink),
		.res_out   (res_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predicted grid state and register copies
	logic [GW_W-1:0]  grid_width_q;
	logic [GH_W-1:0]  grid_height_q;
	logic [ROW_W-1:0] row_two_back;
	logic [ROW_W-1:0] row_one_back;
	int               pass_rows;
	result_t          smoothed_due[$];

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int errors        = 0;
	int rows_sent     = 0;
	int rows_checked  = 0;
	int passes_done   = 0;
	int cycle_count   = 0;

	function automatic int eff_cols();
		int w;
		w = int'(grid_width_q);
		if (w < 3) w = 3;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int eff_rows();
		int h;
		h = int'(grid_height_q);
		if (h < 3) h = 3;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	function automatic logic [ROW_W-1:0] cols_mask(input int cols);
		logic [ROW_W-1:0] m;
		m = '0;
		for (int x = 0; x < cols; x++) m[x] = 1'b1;
		return m;
	endfunction

	// cave rule on interior cells; borders keep the old value
	function automatic logic [ROW_W-1:0] smooth_interior(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] low, input int cols);
		logic [ROW_W-1:0] res;
		int walls;
		res = mid;
		for (int x = 1; x + 1 < cols; x++) begin
			walls = int'(up[x-1]) + int'(up[x]) + int'(up[x+1])
				+ int'(mid[x-1]) + int'(mid[x+1])
				+ int'(low[x-1]) + int'(low[x]) + int'(low[x+1]);
			if (walls > int'(WALL_ABOVE)) res[x] = 1'b1;
			else if (walls < int'(FLOOR_BELOW)) res[x] = 1'b0;
		end
		return res;
	endfunction

	// advance the predicted pass by one row, queue the rows it completes
	function automatic void smooth_step(input logic [ROW_W-1:0] cells);
		logic [ROW_W-1:0] m;
		logic [ROW_W-1:0] row;
		result_t          res;
		int               cols;
		cols = eff_cols();
		m    = cols_mask(cols);
		row  = cells & m;
		if (pass_rows == 0) begin
			row_two_back = '0;
			row_one_back = row;
			pass_rows    = 1;
			return;
		end
		if (pass_rows == 1) res.cells = row_one_back & m;
		else res.cells = smooth_interior(row_two_back & m, row_one_back & m, row, cols) & m;
		res.num = NUM_W'(pass_rows - 1);
		res.fin = 1'b0;
		smoothed_due = {smoothed_due, res};
		if (pass_rows + 1 >= eff_rows()) begin
			res.cells = row;
			res.num   = NUM_W'(pass_rows);
			res.fin   = 1'b1;
			smoothed_due = {smoothed_due, res};
			row_two_back = '0;
			row_one_back = '0;
			pass_rows    = 0;
		end else begin
			row_two_back = row_one_back;
			row_one_back = row;
			pass_rows    = pass_rows + 1;
		end
	endfunction

	// wall density varies so every neighbor count shows up
	function automatic logic [ROW_W-1:0] random_row();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return a;
			4, 5:       return a & b;
			6, 7:       return a | b;
			8:          return a ^ {b[ROW_W-2:0], b[ROW_W-1]};
			default:    return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	// one row transfer, with random idle cycles ahead of it; valid stays high after
	task automatic send_row(input logic [ROW_W-1:0] cells);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			row_ch.valid <= 1'b0;
			@(posedge clk);
		end
		row_ch.valid     <= 1'b1;
		row_ch.row_cells <= cells;
		@(posedge clk);
		while (!row_ch.ready) @(posedge clk);
		smooth_step(cells);
		rows_sent++;
	endtask

	// hold the sender off until every queued result has arrived
	task automatic wait_idle();
		row_ch.valid <= 1'b0;
		@(posedge clk);
		while (smoothed_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers, raw values; only done while idle
	task automatic write_regs(input logic [CFG_DATA_W-1:0] width_raw,
			input logic [CFG_DATA_W-1:0] height_raw);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_wdata <= width_raw;
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_wdata <= height_raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		grid_width_q  = width_raw[GW_W-1:0];
		grid_height_q = height_raw;
	endtask

	// one full pass at the reset geometry, 64 x 64
	task automatic test_reset_geometry();
		src_idle_pct  = 11;
		snk_stall_pct = 85;
		for (int k = 0; k < int'(GH_RESET); k++) send_row(random_row());
		wait_idle();
	endtask

	// extremes, saturation, checkerboard and mid-pass register changes
	task automatic test_directed_edges();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		// smallest height, full width, all walls vs all floor
		write_regs(13'd64, 13'd3);
		send_row('1);
		send_row('0);
		send_row('1);
		send_row('0);
		send_row('1);
		send_row('0);
		wait_idle();
		// width and height below range saturate to three
		write_regs(13'd0, 13'd2);
		send_row(64'hFFFF_FFFF_FFFF_FFFA);
		send_row(64'h0000_0000_0000_0005);
		send_row(64'h8000_0000_0000_0007);
		wait_idle();
		// checkerboard: four neighbors, cells keep their value
		write_regs(13'h1F80 | 13'd64, 13'd3);
		send_row(64'hAAAA_AAAA_AAAA_AAAA);
		send_row(64'h5555_5555_5555_5555);
		send_row(64'hAAAA_AAAA_AAAA_AAAA);
		wait_idle();
		// height dropped below the rows already taken ends the pass on the next row
		write_regs(13'd64, 13'd10);
		for (int k = 0; k < 5; k++) send_row(random_row());
		wait_idle();
		write_regs(13'd64, 13'd4);
		send_row(random_row());
		wait_idle();
		// width narrowed mid-pass re-masks the stored rows
		write_regs(13'd64, 13'd6);
		for (int k = 0; k < 3; k++) send_row('1);
		wait_idle();
		write_regs(13'd5, 13'd6);
		for (int k = 0; k < 3; k++) send_row(random_row());
		wait_idle();
	endtask

	// mostly whole passes of random geometry, some cut short by a register change
	task automatic test_random_passes(input int n_rows, input int src_pct, input int snk_pct);
		int sent;
		int len;
		int pick;
		logic [CFG_DATA_W-1:0] w_raw;
		logic [CFG_DATA_W-1:0] h_raw;
		bit cut_short;
		sent          = 0;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		while (sent < n_rows) begin
			wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 80) w_raw[GW_W-1:0] = GW_W'($urandom_range(3, 64));
			else if (pick < 90) w_raw[GW_W-1:0] = GW_W'($urandom_range(0, 2));
			else w_raw[GW_W-1:0] = GW_W'($urandom_range(65, 127));
			w_raw[CFG_DATA_W-1:GW_W] = (CFG_DATA_W-GW_W)'($urandom);
			pick      = $urandom_range(0, 99);
			cut_short = ($urandom_range(0, 99) < 15);
			if (pick < 70) h_raw = CFG_DATA_W'($urandom_range(3, 16));
			else if (pick < 85) h_raw = CFG_DATA_W'($urandom_range(17, 120));
			else if (pick < 95) h_raw = CFG_DATA_W'($urandom_range(0, 2));
			else begin
				h_raw     = CFG_DATA_W'($urandom_range(4097, 8191));
				cut_short = 1'b1;
			end
			write_regs(w_raw, h_raw);
			len = (eff_rows() > pass_rows) ? eff_rows() - pass_rows : 1;
			if (cut_short && len > 1) begin
				len = $urandom_range(1, len - 1);
				if (len > 20) len = $urandom_range(1, 20);
			end
			for (int k = 0; k < len; k++) send_row(random_row());
			sent += len;
		end
		wait_idle();
	endtask

	// tallest grid, register data all ones: width 127 and height 8191 saturate;
	// only the opening rows of that pass are streamed
	task automatic test_tallest_grid();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		write_regs('1, '1);
		for (int k = 0; k < TALL_ROWS; k++) send_row(random_row());
		wait_idle();
	endtask

	// result side: random stalls and the comparison against the oldest prediction
	result_t want;
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (smoothed_due.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: cells %h row %0d final %b", $time,
					res_ch.smoothed_cells, res_ch.row_number, res_ch.final_row);
			end else begin
				want = smoothed_due.pop_front();
				rows_checked++;
				if (res_ch.final_row) passes_done++;
				if (res_ch.smoothed_cells !== want.cells) begin
					errors++;
					$display("%0t: smoothed_cells expected %h actual %h", $time, want.cells,
						res_ch.smoothed_cells);
				end
				if (res_ch.row_number !== want.num) begin
					errors++;
					$display("%0t: row_number expected %0d actual %0d", $time, want.num,
						res_ch.row_number);
				end
				if (res_ch.final_row !== want.fin) begin
					errors++;
					$display("%0t: final_row expected %b actual %b", $time, want.fin,
						res_ch.final_row);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, smoothed_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_GRID_WIDTH;
		cfg_wdata        <= '0;
		row_ch.valid     <= 1'b0;
		row_ch.row_cells <= '0;
		grid_width_q     = GW_RESET;
		grid_height_q    = GH_RESET;
		row_two_back     = '0;
		row_one_back     = '0;
		pass_rows        = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_directed_edges();
		test_random_passes(RANDOM_ROWS, 11, 85);
		test_random_passes(RANDOM_ROWS, 85, 11);
		test_random_passes(RANDOM_ROWS, 0, 0);
		test_tallest_grid();
		wait_idle();

		$display("Sent %0d rows, checked %0d smoothed rows over %0d grid passes.",
			rows_sent, rows_checked, passes_done);
		$display("Widths 3..64 and heights 3..4096 with saturation, mid-pass changes, %0d errors.",
			errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
